// File: src/canonical_huffman_decoder_unit_macros.svh
// ----------------------------------------------------------------------------
// Canonical Huffman decoder unit: assertion macros
// Shared assertion shorthands. Every user has clk_i and rst_ni in scope.
// ----------------------------------------------------------------------------
`ifndef CANONICAL_HUFFMAN_DECODER_UNIT_MACROS_SVH
`define CANONICAL_HUFFMAN_DECODER_UNIT_MACROS_SVH

// Condition implies consequence in the same cycle
`define CHD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// Condition implies consequence in the next cycle
`define CHD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/chd_pkg.sv
// ----------------------------------------------------------------------------
// chd_pkg
// Types and constants shared by the canonical Huffman decoder modules.
// ----------------------------------------------------------------------------
package chd_pkg;

  localparam int CHD_MAX_CODE_LEN = 24;

  // Request operations
  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_LOAD   = 2'd1,
    OP_BUILD  = 2'd2,
    OP_DECODE = 2'd3
  } op_e;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_WALK_OFF  = 2'd1;
  localparam logic [1:0] ST_BAD_TABLE = 2'd2;
  localparam logic [1:0] ST_NOT_BUILT = 2'd3;

  // Classified request held in the queue
  typedef struct packed {
    op_e        op;
    logic [7:0] sym;
    logic [7:0] len;
    logic [7:0] data;
    logic [3:0] nbits;
  } item_t;

endpackage

// File: src/chd_if.sv
// ----------------------------------------------------------------------------
// chd_if
// Valid/ready channel interfaces for requests and results.
// ----------------------------------------------------------------------------
interface chd_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] entry_symbol;
  logic [7:0] entry_length;
  logic [7:0] data_byte;
  logic [3:0] valid_bits;

  modport source (output valid, op, entry_symbol, entry_length, data_byte, valid_bits,
                  input ready);
  modport sink (input valid, op, entry_symbol, entry_length, data_byte, valid_bits,
                output ready);
endinterface

interface chd_out_if;
  logic       valid;
  logic       ready;
  logic       has_symbol;
  logic [7:0] symbol;
  logic [1:0] status;
  logic       last;

  modport source (output valid, has_symbol, symbol, status, last, input ready);
  modport sink (input valid, has_symbol, symbol, status, last, output ready);
endinterface

// File: src/chd_front.sv
// ----------------------------------------------------------------------------
// chd_front
// Accepts requests, clamps the bit count and queues them for the engine.
// ----------------------------------------------------------------------------
module chd_front
  import chd_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  chd_in_if.sink in_if,
  output logic   valid_o,
  output item_t  item_o,
  input  logic   ready_i
);

  item_t      buf_q [2];
  logic       wp_q, wp_d;
  logic       rp_q, rp_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;
  item_t      cls;

  // Classify the incoming request
  always_comb begin
    cls.op    = op_e'(in_if.op);
    cls.sym   = in_if.entry_symbol;
    cls.len   = in_if.entry_length;
    cls.data  = in_if.data_byte;
    cls.nbits = (in_if.valid_bits > 4'd8) ? 4'd8 : in_if.valid_bits;
  end

  assign in_if.ready = (cnt_q != 2'd2);
  assign push        = in_if.valid && in_if.ready;
  assign valid_o     = (cnt_q != 2'd0);
  assign item_o      = buf_q[rp_q];
  assign pop         = valid_o && ready_i;

  // Advance pointers
  always_comb begin
    wp_d  = push ? ~wp_q : wp_q;
    rp_d  = pop ? ~rp_q : rp_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  // Store payload
  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wp_q] <= cls;
    end
  end

endmodule

// File: src/chd_back.sv
// ----------------------------------------------------------------------------
// chd_back
// Table store, code builder and bit-serial decoder with the result register.
// ----------------------------------------------------------------------------
module chd_back
  import chd_pkg::*;
#(
  parameter int MAX_CODE_LEN = CHD_MAX_CODE_LEN
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  item_t      item_i,
  output logic       ready_o,
  chd_out_if.source  out_if
);

`include "canonical_huffman_decoder_unit_macros.svh"

  localparam int LW = $clog2(MAX_CODE_LEN + 1);
  localparam int WW = MAX_CODE_LEN + 10;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CNT   = 3'd1;
  localparam logic [2:0] S_WALK  = 3'd2;
  localparam logic [2:0] S_PLACE = 3'd3;
  localparam logic [2:0] S_RES   = 3'd4;
  localparam logic [2:0] S_DBIT  = 3'd5;
  localparam logic [2:0] S_DSYM  = 3'd6;

  // Control and scalar state
  logic [2:0]            state_q, state_d;
  logic [8:0]            sa_q, sa_d;
  logic                  pv_q, pv_d;
  logic [7:0]            pa_q, pa_d;
  logic                  fault_q, fault_d;
  logic [8:0]            total_q, total_d;
  logic [LW-1:0]         wl_q, wl_d;
  logic [MAX_CODE_LEN:0] code_q, code_d;
  logic [8:0]            prev_q, prev_d;
  logic [8:0]            off_q, off_d;
  logic [MAX_CODE_LEN:0] used_q, used_d;
  logic                  built_q, built_d;
  logic                  single_q, single_d;
  logic [7:0]            ssym_q, ssym_d;
  logic                  err_q, err_d;
  logic [MAX_CODE_LEN-1:0] pcode_q, pcode_d;
  logic [LW-1:0]         plen_q, plen_d;
  logic [7:0]            byte_q, byte_d;
  logic [3:0]            nb_q, nb_d;
  logic [3:0]            bi_q, bi_d;
  logic                  pend_v_q, pend_v_d;
  logic [7:0]            pend_sym_q, pend_sym_d;

  // Per-length tables
  logic [8:0]            cnt_q   [MAX_CODE_LEN+1];
  logic [MAX_CODE_LEN:0] first_q [MAX_CODE_LEN+1];
  logic [8:0]            nxt_q   [MAX_CODE_LEN+1];

  // Symbol memories
  logic [7:0] len_mem [256];
  logic       len_vld_q [256];
  logic [7:0] sym_mem [256];
  logic [7:0] len_rd_q;
  logic       lv_rd_q;
  logic [7:0] sym_rd_q;

  // Result register
  logic       ov_q, ov_d;
  logic       ohas_q, ohas_d;
  logic [7:0] osym_q, osym_d;
  logic [1:0] ost_q, ost_d;
  logic       olast_q, olast_d;

  // Strobes
  logic          can_emit, emit;
  logic          take;
  logic          cnt_clr, cnt_inc, vld_clr, len_we, len_re, sym_we, sym_re;
  logic          first_we, nxt_set, nxt_inc;
  logic [7:0]    sym_wa, sym_ra;
  logic [LW-1:0] ri;
  logic [8:0]    cnt_r, nxt_r;
  logic [MAX_CODE_LEN:0] first_r;
  logic [7:0]    lval;
  logic          sweep_done;

  // Walk and decode datapath
  logic [MAX_CODE_LEN+1:0] csum;
  logic [MAX_CODE_LEN:0]   code_n;
  logic [MAX_CODE_LEN+1:0] kraft;
  logic [WW-1:0]           used_add;
  logic [MAX_CODE_LEN:0]   pcx;
  logic [MAX_CODE_LEN-1:0] pc;
  logic [LW:0]             pl;
  logic [LW-1:0]           amt;
  logic [WW-1:0]           pcw, diff, span;
  logic                    hit, inspace, dbit, lbit;
  logic [8:0]              idx;

  assign lval    = lv_rd_q ? len_rd_q : 8'd0;
  assign cnt_r   = cnt_q[ri];
  assign nxt_r   = nxt_q[ri];
  assign first_r = first_q[ri];
  assign sweep_done = sa_q[8] && !pv_q;
  assign can_emit = !ov_q || out_if.ready;
  assign ready_o  = (state_q == S_IDLE) && can_emit;
  assign take     = valid_i && ready_o;

  // Select the length index shared by table reads and writes
  always_comb begin
    unique case (state_q)
      S_WALK:        ri = wl_q;
      S_DBIT:        ri = pl[LW-1:0];
      S_CNT, S_PLACE: ri = lval[LW-1:0];
      default:       ri = '0;
    endcase
  end

  // Walk arithmetic: next first code and Kraft check
  always_comb begin
    csum     = (MAX_CODE_LEN+2)'(code_q) + (MAX_CODE_LEN+2)'(prev_q);
    code_n   = {csum[MAX_CODE_LEN-1:0], 1'b0};
    kraft    = (MAX_CODE_LEN+2)'(code_n) + (MAX_CODE_LEN+2)'(cnt_r);
    used_add = WW'(cnt_r) << (LW'(MAX_CODE_LEN) - wl_q);
  end

  // Decode arithmetic: one tree step
  always_comb begin
    dbit    = byte_q[3'd7 - bi_q[2:0]];
    pcx     = {pcode_q, dbit};
    pc      = pcx[MAX_CODE_LEN-1:0];
    pl      = {1'b0, plen_q} + (LW+1)'(1);
    amt     = LW'(MAX_CODE_LEN) - pl[LW-1:0];
    pcw     = WW'(pc);
    diff    = pcw - WW'(first_r);
    hit     = (pcw >= WW'(first_r)) && (diff < WW'(cnt_r));
    span    = pcw << amt;
    inspace = span < WW'(used_q);
    idx     = nxt_r - cnt_r + diff[8:0];
    lbit    = (bi_q + 4'd1 == nb_q);
  end

  // Sequencer
  always_comb begin
    state_d = state_q;   sa_d = sa_q;       pv_d = 1'b0;      pa_d = pa_q;
    fault_d = fault_q;   total_d = total_q; wl_d = wl_q;      code_d = code_q;
    prev_d = prev_q;     off_d = off_q;     used_d = used_q;  built_d = built_q;
    single_d = single_q; ssym_d = ssym_q;   err_d = err_q;    pcode_d = pcode_q;
    plen_d = plen_q;     byte_d = byte_q;   nb_d = nb_q;      bi_d = bi_q;
    pend_v_d = pend_v_q; pend_sym_d = pend_sym_q;
    cnt_clr = 1'b0; cnt_inc = 1'b0; vld_clr = 1'b0; len_we = 1'b0; len_re = 1'b0;
    sym_we = 1'b0;  sym_re = 1'b0;  first_we = 1'b0; nxt_set = 1'b0; nxt_inc = 1'b0;
    sym_wa = nxt_r[7:0]; sym_ra = idx[7:0];
    emit = 1'b0; ohas_d = 1'b0; osym_d = 8'd0; ost_d = ST_OK; olast_d = 1'b1;

    unique case (state_q)
      S_IDLE: begin
        if (take) begin
          unique case (item_i.op)
            OP_CLEAR: begin
              cnt_clr = 1'b1; vld_clr = 1'b1;
              built_d = 1'b0; single_d = 1'b0; err_d = 1'b0;
              pcode_d = '0;   plen_d = '0;
            end
            OP_LOAD: begin
              len_we = 1'b1; built_d = 1'b0; single_d = 1'b0;
            end
            OP_BUILD: begin
              cnt_clr = 1'b1; fault_d = 1'b0; total_d = 9'd0; sa_d = 9'd0;
              pcode_d = '0;   plen_d = '0;    err_d = 1'b0;
              state_d = S_CNT;
            end
            OP_DECODE: begin
              priority if (!built_q) begin
                emit = 1'b1; ost_d = ST_NOT_BUILT;
              end else if (err_q) begin
                emit = 1'b1; ost_d = ST_WALK_OFF;
              end else begin
                byte_d = item_i.data; nb_d = item_i.nbits;
                bi_d = 4'd0; pend_v_d = 1'b0;
                state_d = S_DBIT;
              end
            end
            default: ;
          endcase
        end
      end

      // Count codes per length
      S_CNT: begin
        if (!sa_q[8]) begin
          len_re = 1'b1; pv_d = 1'b1; pa_d = sa_q[7:0]; sa_d = sa_q + 9'd1;
        end
        if (pv_q) begin
          if (lval > 8'(MAX_CODE_LEN)) begin
            fault_d = 1'b1;
          end else if (lval != 8'd0) begin
            cnt_inc = 1'b1; total_d = total_q + 9'd1;
          end
        end
        if (sweep_done) begin
          wl_d = LW'(1); code_d = '0; prev_d = 9'd0; off_d = 9'd0; used_d = '0;
          state_d = fault_q ? S_RES : S_WALK;
        end
      end

      // Assign first codes and offsets, one length per cycle
      S_WALK: begin
        first_we = 1'b1; nxt_set = 1'b1;
        code_d = code_n; prev_d = cnt_r; off_d = off_q + cnt_r;
        used_d = used_q + used_add[MAX_CODE_LEN:0];
        wl_d   = wl_q + LW'(1);
        if (kraft > ((MAX_CODE_LEN+2)'(1) << wl_q)) begin
          fault_d = 1'b1; state_d = S_RES;
        end else if (wl_q == LW'(MAX_CODE_LEN)) begin
          sa_d = 9'd0; state_d = S_PLACE;
        end
      end

      // Place symbols in code order
      S_PLACE: begin
        if (!sa_q[8]) begin
          len_re = 1'b1; pv_d = 1'b1; pa_d = sa_q[7:0]; sa_d = sa_q + 9'd1;
        end
        if (pv_q && lval != 8'd0) begin
          sym_we = 1'b1; nxt_inc = 1'b1;
          if (total_q == 9'd1) begin
            ssym_d = pa_q;
          end
        end
        if (sweep_done) begin
          state_d = S_RES;
        end
      end

      S_RES: begin
        if (can_emit) begin
          emit = 1'b1; ost_d = fault_q ? ST_BAD_TABLE : ST_OK;
          built_d  = !fault_q;
          single_d = !fault_q && (total_q == 9'd1);
          state_d  = S_IDLE;
        end
      end

      // One stream bit per step; a decoded symbol waits until the next result
      // or the end of the byte shows whether it is the last one
      S_DBIT: begin
        if (can_emit) begin
          priority if (bi_q == nb_q) begin
            emit = 1'b1; ohas_d = pend_v_q; osym_d = pend_v_q ? pend_sym_q : 8'd0;
            pend_v_d = 1'b0; state_d = S_IDLE;
          end else if (single_q) begin
            emit = 1'b1; ohas_d = 1'b1; osym_d = ssym_q; olast_d = lbit;
            bi_d = bi_q + 4'd1;
            if (lbit) begin
              state_d = S_IDLE;
            end
          end else if (pl > (LW+1)'(MAX_CODE_LEN) || !(hit || inspace)) begin
            if (pend_v_q) begin
              // Release the held symbol, then retry this bit
              emit = 1'b1; ohas_d = 1'b1; osym_d = pend_sym_q; olast_d = 1'b0;
              pend_v_d = 1'b0;
            end else begin
              err_d = 1'b1; pcode_d = '0; plen_d = '0;
              emit = 1'b1; ost_d = ST_WALK_OFF; state_d = S_IDLE;
            end
          end else if (hit) begin
            if (pend_v_q) begin
              emit = 1'b1; ohas_d = 1'b1; osym_d = pend_sym_q; olast_d = 1'b0;
              pend_v_d = 1'b0;
            end
            sym_re = 1'b1; bi_d = bi_q + 4'd1;
            pcode_d = '0; plen_d = '0; state_d = S_DSYM;
          end else begin
            pcode_d = pc; plen_d = pl[LW-1:0]; bi_d = bi_q + 4'd1;
          end
        end
      end

      // Hold the symbol read from the code-order memory
      S_DSYM: begin
        pend_v_d = 1'b1; pend_sym_d = sym_rd_q;
        state_d  = S_DBIT;
      end

      default: state_d = S_IDLE;
    endcase

    ov_d = emit ? 1'b1 : (out_if.ready ? 1'b0 : ov_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; sa_q <= 9'd0; pv_q <= 1'b0; fault_q <= 1'b0;
      total_q <= 9'd0; built_q <= 1'b0; single_q <= 1'b0; err_q <= 1'b0;
      pcode_q <= '0; plen_q <= '0; pend_v_q <= 1'b0; ov_q <= 1'b0;
    end else begin
      state_q <= state_d; sa_q <= sa_d; pv_q <= pv_d; fault_q <= fault_d;
      total_q <= total_d; built_q <= built_d; single_q <= single_d; err_q <= err_d;
      pcode_q <= pcode_d; plen_q <= plen_d; pend_v_q <= pend_v_d; ov_q <= ov_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    pa_q <= pa_d; wl_q <= wl_d; code_q <= code_d; prev_q <= prev_d;
    off_q <= off_d; used_q <= used_d; ssym_q <= ssym_d; byte_q <= byte_d;
    nb_q <= nb_d; bi_q <= bi_d; pend_sym_q <= pend_sym_d;
    if (emit) begin
      ohas_q <= ohas_d; osym_q <= osym_d; ost_q <= ost_d; olast_q <= olast_d;
    end
  end

  // Count table, cleared at once
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= MAX_CODE_LEN; k++) cnt_q[k] <= 9'd0;
    end else if (cnt_clr) begin
      for (int k = 0; k <= MAX_CODE_LEN; k++) cnt_q[k] <= 9'd0;
    end else if (cnt_inc) begin
      cnt_q[ri] <= cnt_r + 9'd1;
    end
  end

  // First codes and next slots
  always_ff @(posedge clk_i) begin
    if (first_we) begin
      first_q[ri] <= code_n;
    end
    if (nxt_set) begin
      nxt_q[ri] <= off_q;
    end else if (nxt_inc) begin
      nxt_q[ri] <= nxt_r + 9'd1;
    end
  end

  // Length valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 256; k++) len_vld_q[k] <= 1'b0;
    end else if (vld_clr) begin
      for (int k = 0; k < 256; k++) len_vld_q[k] <= 1'b0;
    end else if (len_we) begin
      len_vld_q[item_i.sym] <= 1'b1;
    end
  end

  // Length memory
  always_ff @(posedge clk_i) begin
    if (len_we) begin
      len_mem[item_i.sym] <= item_i.len;
    end
    if (len_re) begin
      len_rd_q <= len_mem[sa_q[7:0]];
      lv_rd_q  <= len_vld_q[sa_q[7:0]];
    end
  end

  // Code-order symbol memory
  always_ff @(posedge clk_i) begin
    if (sym_we) begin
      sym_mem[sym_wa] <= pa_q;
    end
    if (sym_re) begin
      sym_rd_q <= sym_mem[sym_ra];
    end
  end

  assign out_if.valid      = ov_q;
  assign out_if.has_symbol = ohas_q;
  assign out_if.symbol     = osym_q;
  assign out_if.status     = ost_q;
  assign out_if.last       = olast_q;

  // Checks
  `CHD_ASSERT_IMPL(a_plen_range, 1'b1, plen_q <= LW'(MAX_CODE_LEN), "partial length out of range")
  `CHD_ASSERT_IMPL(a_dec_built, state_q == S_DBIT || state_q == S_DSYM, built_q && !err_q, "decoding without a good table")
  `CHD_ASSERT_IMPL(a_single_no_partial, single_q, plen_q == '0, "partial code used in single-symbol mode")
  `CHD_ASSERT_IMPL(a_place_no_fault, state_q == S_PLACE, !fault_q, "placing symbols of a bad table")
  `CHD_ASSERT_NEXT(a_err_result, state_q == S_DBIT && !err_q && err_d, ov_q && ost_q == ST_WALK_OFF && olast_q, "walk-off without error result")

endmodule

// File: src/canonical_huffman_decoder_unit.sv
// Canonical Huffman decoder. Requests clear the table, load (symbol, length)
// pairs, build canonical codes or decode one byte MSB first. A decode walks
// the tree one stream bit per step, reads each decoded symbol through the
// registered read of the code-order symbol memory and ends with a closing
// result; a walk-off right after a decoded symbol first releases that symbol.
// With a single-symbol table each bit yields that symbol. Each walked symbol
// is held back until the next result or the end of the byte, so the final
// result always carries last. A build sweeps the 256-entry length memory to
// count codes per length, walks the code lengths and sweeps it again to place
// symbols; a bad length or an oversubscribed table ends it early. Clear and
// load complete when taken. A two-entry request queue and a result register
// decouple both sides.
// ----------------------------------------------------------------------------
// canonical_huffman_decoder_unit
// Top level: request front end and table/decode engine.
// ----------------------------------------------------------------------------
module canonical_huffman_decoder_unit
  import chd_pkg::*;
#(
  parameter int MAX_CODE_LEN = CHD_MAX_CODE_LEN
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  chd_in_if.sink     in_if,
  chd_out_if.source  out_if
);

  logic  q_valid;
  logic  q_ready;
  item_t q_item;

  // Accept and queue requests
  chd_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_if   (in_if),
    .valid_o (q_valid),
    .item_o  (q_item),
    .ready_i (q_ready)
  );

  // Execute requests
  chd_back #(
    .MAX_CODE_LEN (MAX_CODE_LEN)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (q_valid),
    .item_i  (q_item),
    .ready_o (q_ready),
    .out_if  (out_if)
  );

endmodule

// File: bench/canonical_huffman_decoder_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// canonical_huffman_decoder_unit_tb
// Drives clear, load, build and decode requests into the decoder, keeps its
// own model of the code tables and the bit stream, and compares every result
// in order. Random tables come from splitting leaves of a complete code tree,
// with some bad and incomplete tables mixed in; both channels idle at random.
// ----------------------------------------------------------------------------
module canonical_huffman_decoder_unit_tb;
  import chd_pkg::*;

  localparam int LIMIT_CYCLES = 600000;
  localparam int ML = CHD_MAX_CODE_LEN;

  typedef struct packed {
    logic       has_symbol;
    logic [7:0] symbol;
    logic [1:0] status;
    logic       last;
  } result_t;

  // Expected results and the decoder state that produces them
  class huff_scoreboard;
    result_t           expected_q[$];
    int                errors;
    logic [7:0]        len_of_sym[256];
    int                len_count[ML+1];
    longint unsigned   first_code[ML+1];
    logic [7:0]        code_order[256];
    longint unsigned   part_code;
    int                part_len;
    bit                built;
    bit                single;
    bit                stream_err;

    function new();
      errors = 0;
      clear_all();
    endfunction

    function void clear_all();
      foreach (len_of_sym[s]) len_of_sym[s] = 8'd0;
      foreach (code_order[s]) code_order[s] = 8'd0;
      foreach (len_count[l]) begin
        len_count[l] = 0;
        first_code[l] = 0;
      end
      part_code = 0;
      part_len = 0;
      built = 0;
      single = 0;
      stream_err = 0;
    endfunction

    function int offset_of(int len);
      int off;
      off = 0;
      for (int l = 1; l < len && l <= ML; l++) off += len_count[l];
      return off;
    endfunction

    function longint unsigned code_space();
      longint unsigned k;
      k = 0;
      for (int l = 1; l <= ML; l++) k += longint'(len_count[l]) << (ML - l);
      return k;
    endfunction

    // Assign canonical codes; return the build status
    function logic [1:0] build_codes();
      int              next[ML+1];
      int              total;
      longint unsigned code;
      bit              fault;
      int              l;
      total = 0;
      code = 0;
      fault = 0;
      foreach (len_count[i]) begin
        len_count[i] = 0;
        first_code[i] = 0;
      end
      for (int s = 0; s < 256; s++) begin
        l = len_of_sym[s];
        if (l == 0) continue;
        if (l > ML) begin
          fault = 1;
          continue;
        end
        len_count[l]++;
        total++;
      end
      if (!fault) begin
        for (int j = 1; j <= ML; j++) begin
          code = (code + len_count[j-1]) << 1;
          first_code[j] = code;
          if (code + len_count[j] > (64'd1 << j)) fault = 1;
        end
      end
      part_code = 0;
      part_len = 0;
      stream_err = 0;
      if (fault) begin
        built = 0;
        single = 0;
        return ST_BAD_TABLE;
      end
      for (int j = 0; j <= ML; j++) next[j] = offset_of(j);
      for (int s = 0; s < 256; s++) begin
        l = len_of_sym[s];
        if (l == 0 || l > ML) continue;
        code_order[next[l] & 255] = s[7:0];
        next[l]++;
      end
      built = 1;
      single = (total == 1);
      return ST_OK;
    endfunction

    // Append one expected result, not yet marked last
    function void add_result(logic has, logic [7:0] sym, logic [1:0] st);
      result_t r;
      r = '{has, sym, st, 1'b0};
      expected_q = {expected_q, r};
    endfunction

    // Predict the results of one accepted request
    function void note(item_t it);
      int              n0;
      int              nb;
      longint unsigned pc;
      longint unsigned idx;
      int              pl;
      n0 = expected_q.size();
      case (it.op)
        OP_CLEAR: clear_all();
        OP_LOAD: begin
          len_of_sym[it.sym] = it.len;
          built = 0;
          single = 0;
        end
        OP_BUILD: add_result(1'b0, 8'd0, build_codes());
        default: begin
          if (!built) add_result(1'b0, 8'd0, ST_NOT_BUILT);
          else if (stream_err) add_result(1'b0, 8'd0, ST_WALK_OFF);
          else begin
            nb = (it.nbits > 8) ? 8 : it.nbits;
            for (int i = 0; i < nb; i++) begin
              if (single) begin
                add_result(1'b1, code_order[0], ST_OK);
                continue;
              end
              pc = (part_code << 1) | it.data[7-i];
              pl = part_len + 1;
              if (pl > ML) begin
                stream_err = 1;
                add_result(1'b0, 8'd0, ST_WALK_OFF);
                break;
              end
              if (pc >= first_code[pl] && pc - first_code[pl] < len_count[pl]) begin
                idx = offset_of(pl) + (pc - first_code[pl]);
                add_result(1'b1, code_order[idx[7:0]], ST_OK);
                part_code = 0;
                part_len = 0;
              end else if ((pc << (ML - pl)) < code_space()) begin
                part_code = pc;
                part_len = pl;
              end else begin
                stream_err = 1;
                part_code = 0;
                part_len = 0;
                add_result(1'b0, 8'd0, ST_WALK_OFF);
                break;
              end
            end
            if (expected_q.size() == n0) add_result(1'b0, 8'd0, ST_OK);
          end
        end
      endcase
      if (expected_q.size() > n0) expected_q[expected_q.size() - 1].last = 1'b1;
    endfunction

    function void report(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endfunction

    // Compare one result with the oldest expectation
    function void check(result_t got);
      result_t exp_r;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result %p", got));
        return;
      end
      exp_r = expected_q.pop_front();
      if (got.has_symbol !== exp_r.has_symbol)
        report($sformatf("has_symbol %b, want %b", got.has_symbol, exp_r.has_symbol));
      if (got.symbol !== exp_r.symbol)
        report($sformatf("symbol %h, want %h", got.symbol, exp_r.symbol));
      if (got.status !== exp_r.status)
        report($sformatf("status %0d, want %0d", got.status, exp_r.status));
      if (got.last !== exp_r.last)
        report($sformatf("last %b, want %b", got.last, exp_r.last));
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  chd_in_if  in_if ();
  chd_out_if out_if ();

  canonical_huffman_decoder_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if.sink),
    .out_if (out_if.source)
  );

  huff_scoreboard sb = new();
  int  cycles = 0;
  int  hold_cycles;
  bit  calm;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Bound the run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Send one request, idling before it at random
  task automatic send(op_e op, logic [7:0] sym, logic [7:0] len, logic [7:0] data,
                      logic [3:0] nbits);
    item_t it;
    it = '{op, sym, len, data, nbits};
    if (!calm && $urandom_range(99) < 30) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.op           <= op;
    in_if.entry_symbol <= sym;
    in_if.entry_length <= len;
    in_if.data_byte    <= data;
    in_if.valid_bits   <= nbits;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note(it);
  endtask

  // Requests with random content in the fields the op ignores
  task automatic send_op(op_e op);
    send(op, 8'($urandom), 8'($urandom), 8'($urandom), 4'($urandom));
  endtask

  task automatic load(logic [7:0] sym, logic [7:0] len);
    send(OP_LOAD, sym, len, 8'($urandom), 4'($urandom));
  endtask

  task automatic decode(logic [7:0] data, logic [3:0] nbits);
    send(OP_DECODE, 8'($urandom), 8'($urandom), data, nbits);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_q.size() != 0) @(posedge clk_i);
  endtask

  // Receive results, stalling at random or for a long hold
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_if.valid && out_if.ready)
        sb.check('{out_if.has_symbol, out_if.symbol, out_if.status, out_if.last});
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= calm || ($urandom_range(99) >= 30);
      end
    end
  end

  // Random table from splitting leaves of a complete tree
  task automatic random_phase(int phase_idx);
    int         lens[$];
    bit [255:0] used;
    int         n, pick, l, kind;
    logic [7:0] s;
    if ($urandom_range(3) != 0) send_op(OP_CLEAR);
    lens = '{1, 1};
    n = $urandom_range(2, 9);
    while (lens.size() < n) begin
      pick = ($urandom_range(3) == 0) ? lens.size() - 1 : $urandom_range(lens.size() - 1);
      l = lens[pick];
      if (l >= ML) break;
      lens.delete(pick);
      lens = {lens, l + 1, l + 1};
    end
    kind = $urandom_range(9);
    if (kind == 0) lens = {lens, 1};
    else if (kind == 1) lens[0] = $urandom_range(ML + 1, 255);
    else if (kind == 2) void'(lens.pop_front());
    used = '0;
    foreach (lens[i]) begin
      do s = 8'($urandom); while (used[s]);
      used[s] = 1'b1;
      load(s, 8'(lens[i]));
    end
    // Load and then remove a stray symbol now and then
    if ($urandom_range(3) == 0) begin
      do s = 8'($urandom); while (used[s]);
      load(s, 8'($urandom_range(1, 30)));
      load(s, 8'd0);
    end
    send_op(OP_BUILD);
    if (phase_idx == 3) hold_cycles = 400;
    repeat ($urandom_range(6, 12)) begin
      if ($urandom_range(5) == 0) decode(8'($urandom), 4'($urandom));
      else decode(8'($urandom), 4'($urandom_range(1, 8)));
    end
    if (phase_idx == 4) drain();
  endtask

  initial begin
    int phase_idx;
    rst_ni <= 1'b0;
    hold_cycles = 0;
    calm = 0;
    in_if.valid        <= 1'b0;
    in_if.op           <= OP_CLEAR;
    in_if.entry_symbol <= 8'd0;
    in_if.entry_length <= 8'd0;
    in_if.data_byte    <= 8'd0;
    in_if.valid_bits   <= 4'd0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Not built, empty table, walk off, sticky error
    decode(8'hff, 4'd8);
    send_op(OP_BUILD);
    decode(8'hff, 4'd8);
    decode(8'h00, 4'd8);
    // Length above the maximum
    load(8'ha5, 8'd200);
    send_op(OP_BUILD);
    decode(8'h00, 4'd8);
    // Single symbol, zero and oversized bit counts
    load(8'ha5, 8'd3);
    send_op(OP_BUILD);
    decode(8'h12, 4'd0);
    decode(8'h34, 4'd15);
    // Oversubscribed, then a good two-symbol table
    send_op(OP_CLEAR);
    load(8'h00, 8'd1);
    load(8'hff, 8'd1);
    load(8'h10, 8'd1);
    send_op(OP_BUILD);
    load(8'h10, 8'd0);
    send_op(OP_BUILD);
    decode(8'h5a, 4'd8);
    // Longest codes, then a bit off the tree
    send_op(OP_CLEAR);
    load(8'h01, 8'd24);
    load(8'h02, 8'd24);
    send_op(OP_BUILD);
    decode(8'h00, 4'd8);
    decode(8'h00, 4'd8);
    decode(8'h00, 4'd8);
    decode(8'h80, 4'd8);

    // Random phases; a few in the middle run with no idling
    for (phase_idx = 0; phase_idx < 12; phase_idx++) begin
      calm = (phase_idx >= 7 && phase_idx <= 8);
      random_phase(phase_idx);
    end
    calm = 0;

    drain();
    repeat (600) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+src
src/chd_pkg.sv
src/chd_if.sv
src/chd_front.sv
src/chd_back.sv
src/canonical_huffman_decoder_unit.sv
bench/canonical_huffman_decoder_unit_tb.sv
